[sv/hef_pkg.sv]
`timescale 1ns / 1ps
package hef_pkg;

    localparam int STREAMS     = 8;
    localparam int SLOT_W      = 3;
    localparam int SAMPLE_BITS = 24;
    localparam int SLOT_WORDS  = 33;
    localparam int MEM_DEPTH   = STREAMS * SLOT_WORDS;
    localparam int ADDR_W      = 9;
    localparam int ENV_W       = 25;
    localparam int RECIP_W     = 32;

    localparam logic [ENV_W-1:0]   ENV_MAX   = {ENV_W{1'b1}};
    localparam logic [RECIP_W-1:0] RECIP_MAX = {RECIP_W{1'b1}};

    localparam logic [1:0] REG_RELEASE    = 2'd0;
    localparam logic [1:0] REG_OVERSAMPLE = 2'd1;

    typedef enum logic [4:0] {
        ST_IDLE, ST_RD0, ST_RD1, ST_YC, ST_M2, ST_W0, ST_DR, ST_DW,
        ST_SQ1, ST_SQ2, ST_SQ3, ST_SQRT0, ST_SQRT, ST_REL1, ST_REL2, ST_REL3,
        ST_DIV0, ST_DIV, ST_OUT
    } state_t;

    // Section coefficients, Q0.24; chain one then chain two.
    function automatic logic signed [31:0] coef(input logic [3:0] idx);
        logic signed [31:0] c;
        case (idx)
            4'd0:    c = 32'sd16769391;
            4'd1:    c = 32'sd16727272;
            4'd2:    c = 32'sd16629309;
            4'd3:    c = 32'sd16367803;
            4'd4:    c = 32'sd15668065;
            4'd5:    c = 32'sd13884142;
            4'd6:    c = 32'sd9914629;
            4'd7:    c = 32'sd3688505;
            4'd8:    c = 32'sd16751688;
            4'd9:    c = 32'sd16689741;
            4'd10:   c = 32'sd16530376;
            4'd11:   c = 32'sd16101368;
            4'd12:   c = 32'sd14973105;
            4'd13:   c = 32'sd12241872;
            4'd14:   c = 32'sd6932359;
            default: c = 32'sd1040021;
        endcase
        return c;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
        logic signed [31:0] r;
        if (v > 42'sd2147483647) r = 32'sh7FFFFFFF;
        else if (v < -42'sd2147483648) r = 32'sh80000000;
        else r = v[31:0];
        return r;
    endfunction

endpackage

[sv/hef_sqrt.sv]
`timescale 1ns / 1ps
module hef_sqrt import hef_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] value,
    output logic [31:0] root,
    output logic        done
);
    logic [63:0] v_reg, v_next;
    logic [35:0] rem_reg, rem_next;
    logic [31:0] root_reg, root_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [35:0] shifted, trial;

    always_comb begin
        v_next    = v_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[33:0], v_reg[63:62]};
        trial     = {2'b00, root_reg, 2'b01};
        if (start) begin
            v_next    = value;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // one result bit a step
            v_next = {v_reg[61:0], 2'b00};
            if (shifted >= trial) begin
                rem_next  = shifted - trial;
                root_next = {root_reg[30:0], 1'b1};
            end else begin
                rem_next  = shifted;
                root_next = {root_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        v_reg    <= v_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        cnt_reg  <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign root = root_reg;
    assign done = done_reg;
endmodule

[sv/hef_recip.sv]
`timescale 1ns / 1ps
module hef_recip import hef_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [ENV_W-1:0]   den,
    output logic [RECIP_W-1:0] quot,
    output logic               done
);
    logic [ENV_W-1:0] den_reg, den_next;
    logic [ENV_W:0]   rem_reg, rem_next;
    logic [39:0]      q_reg, q_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [ENV_W:0]   shifted;

    always_comb begin
        den_next  = den_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        // dividend is 2^39: its only set bit enters on the first step
        shifted   = {rem_reg[ENV_W-1:0], (cnt_reg == 6'd0)};
        if (start) begin
            den_next  = den;
            rem_next  = '0;
            q_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (shifted >= {1'b0, den_reg}) begin
                rem_next = shifted - {1'b0, den_reg};
                q_next   = {q_reg[38:0], 1'b1};
            end else begin
                rem_next = shifted;
                q_next   = {q_reg[38:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd39) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        den_reg <= den_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign quot = (q_reg[39:32] != 8'd0) ? RECIP_MAX : q_reg[31:0];
    assign done = done_reg;
endmodule

[sv/hilbert_envelope_follower.sv]
`timescale 1ns / 1ps
// Hilbert envelope follower for up to eight interleaved streams.
// Input words: s_tuser carries the stream slot, s_tdata the signed sample.
// Each word yields exactly one result word on the m_ side: slot in m_tuser,
// envelope and reciprocal packed in m_tdata.
// Only the first word of each oversample group is filtered. It runs sixteen
// allpass sections through one shared 32x32 multiplier, a delay tap,
// squaring, a bit-serial square root, release smoothing and a bit-serial
// reciprocal divide; no divide runs when the envelope is zero.
// Other words of a group skip the filter and return the slot's held
// envelope and reciprocal.
// One word is in flight at a time; s_tready is high only when idle, so the
// next word is accepted only once the current result is in the output
// register. A finished result waits in the output register while m_tready
// is low; the next word is accepted meanwhile and its result waits behind it.
// Reset (aresetn low, synchronous) clears levels and group phases, sets held
// reciprocals to all ones, release_coef to 0 and the group length to 1. A
// slot's delay memory reads as zero until that slot has been filtered once.
// Configuration: cfg_we writes cfg_data to register cfg_addr (0 release_coef,
// 1 group length); the user must write only when idle; the block won't check.
module hilbert_envelope_follower import hef_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [23:0] sample
    input  logic [2:0]  s_tuser,   // [2:0] stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [24:0] envelope, [56:25] reciprocal
    output logic [2:0]  m_tuser,   // [2:0] stream_res
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_data
);
    state_t state_reg, state_next;

    logic [15:0] rel_coef_reg;
    logic [4:0]  os_factor_reg;
    logic [4:0]  factor;

    logic [ENV_W-1:0]   level_reg [STREAMS];
    logic [3:0]         phase_reg [STREAMS];
    logic [RECIP_W-1:0] held_reg  [STREAMS];
    logic [STREAMS-1:0] slot_valid_reg;

    logic [31:0]   mem [MEM_DEPTH];
    logic [31:0]   mem_q;
    logic [ADDR_W-1:0] raddr, waddr, base;
    logic          mem_we;
    logic [31:0]   wdata;
    logic signed [31:0] rd;

    logic [SLOT_W-1:0] slot_reg;
    logic [3:0]    sec_reg;
    logic signed [31:0] x_reg, a_reg, st0_reg, y_reg, re_reg;
    logic signed [31:0] mul_a, mul_b, cur_coef;
    logic signed [63:0] prod_reg;
    logic signed [40:0] prod_rnd;
    logic [63:0]   sq_reg;
    logic [ENV_W-1:0] env_reg;
    logic [ENV_W-1:0] lvl;
    logic [27:0]   mag;
    logic [40:0]   rel_add;

    logic          sqrt_start, sqrt_done, div_start, div_done;
    logic [31:0]   sqrt_root;
    logic [RECIP_W-1:0] div_q;

    logic          m_valid_reg;
    logic [SLOT_W-1:0] m_slot_reg;
    logic [ENV_W-1:0]  m_env_reg;
    logic [RECIP_W-1:0] m_recip_reg;
    logic          out_load;
    logic [4:0]    ph_inc;
    logic [3:0]    ph_cur;

    assign factor = (os_factor_reg == 5'd0) ? 5'd1 :
                    (os_factor_reg > 5'd16) ? 5'd16 : os_factor_reg;
    assign ph_cur = phase_reg[s_tuser];
    assign ph_inc = {1'b0, ph_cur} + 5'd1;

    assign base     = ADDR_W'({slot_reg, 5'b0}) + ADDR_W'(slot_reg);
    assign cur_coef = coef(sec_reg);
    assign rd       = slot_valid_reg[slot_reg] ? mem_q : 32'sd0;
    assign prod_rnd = 41'((prod_reg + 64'sd8388608) >>> 24);
    assign lvl      = level_reg[slot_reg];
    assign mag      = sqrt_root[31:4];
    assign rel_add  = 41'((prod_reg[40:0] + 41'd32768) >> 16);

    assign s_tready = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = (ph_cur == 4'd0) ? ST_RD0 : ST_OUT;
            ST_RD0:  state_next = ST_RD1;
            ST_RD1:  state_next = ST_YC;
            ST_YC:   state_next = ST_M2;
            ST_M2:   state_next = ST_W0;
            ST_W0: begin
                if (sec_reg == 4'd7) state_next = ST_DR;
                else if (sec_reg == 4'd15) state_next = ST_SQ1;
                else state_next = ST_RD0;
            end
            ST_DR:   state_next = ST_DW;
            ST_DW:   state_next = ST_RD0;
            ST_SQ1:  state_next = ST_SQ2;
            ST_SQ2:  state_next = ST_SQ3;
            ST_SQ3:  state_next = ST_SQRT0;
            ST_SQRT0: state_next = ST_SQRT;
            ST_SQRT: if (sqrt_done) state_next = ST_REL1;
            ST_REL1: state_next = ST_REL2;
            ST_REL2: state_next = ST_REL3;
            ST_REL3: state_next = ST_DIV0;
            // zero envelope: no divide, reciprocal is all ones
            ST_DIV0: state_next = (env_reg == '0) ? ST_OUT : ST_DIV;
            ST_DIV:  if (div_done) state_next = ST_OUT;
            ST_OUT:  if (!m_valid_reg || m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        raddr  = base + ADDR_W'({sec_reg, 1'b0});
        waddr  = raddr;
        mem_we = 1'b0;
        wdata  = a_reg;
        mul_a  = a_reg;
        mul_b  = cur_coef;
        sqrt_start = (state_reg == ST_SQRT0);
        div_start  = (state_reg == ST_DIV0) && (env_reg != '0);
        case (state_reg)
            ST_RD1: raddr = base + ADDR_W'({sec_reg, 1'b1});
            ST_YC: begin
                waddr  = base + ADDR_W'({sec_reg, 1'b1});
                mem_we = 1'b1;
                wdata  = st0_reg;
            end
            ST_M2:  mul_a = y_reg;
            ST_W0: begin
                mem_we = 1'b1;
                wdata  = sat32(42'(a_reg) + 42'(prod_rnd));
            end
            ST_DR:  raddr = base + ADDR_W'(SLOT_WORDS - 1);
            ST_DW: begin
                waddr  = base + ADDR_W'(SLOT_WORDS - 1);
                mem_we = 1'b1;
                wdata  = a_reg;
            end
            ST_SQ1: begin
                mul_a = re_reg;
                mul_b = re_reg;
            end
            ST_SQ2: mul_b = a_reg;
            ST_REL2: begin
                mul_a = 32'(lvl - env_reg);
                mul_b = 32'(rel_coef_reg);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) mem[waddr] <= wdata;
        mem_q    <= mem[raddr];
        prod_reg <= mul_a * mul_b;
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                slot_reg <= s_tuser;
                x_reg    <= 32'(signed'(s_tdata)) <<< 4;
                a_reg    <= 32'(signed'(s_tdata)) <<< 4;
                sec_reg  <= '0;
            end
            ST_RD1: st0_reg <= rd;
            ST_YC:  y_reg <= sat32(42'(rd) - 42'(prod_rnd));
            ST_W0: begin
                a_reg   <= y_reg;
                sec_reg <= sec_reg + 4'd1;
            end
            ST_DW: begin
                re_reg <= rd;
                a_reg  <= x_reg;
            end
            ST_SQ2: sq_reg <= prod_reg;
            ST_SQ3: sq_reg <= sq_reg + prod_reg;
            ST_REL1: env_reg <= (mag > 28'(ENV_MAX)) ? ENV_MAX : mag[ENV_W-1:0];
            ST_REL3: if (env_reg < lvl) env_reg <= env_reg + rel_add[ENV_W-1:0];
            default: ;
        endcase
        if (out_load) begin
            m_slot_reg  <= slot_reg;
            m_env_reg   <= level_reg[slot_reg];
            m_recip_reg <= held_reg[slot_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            rel_coef_reg   <= '0;
            os_factor_reg  <= 5'd1;
            slot_valid_reg <= '0;
            m_valid_reg    <= 1'b0;
            for (int i = 0; i < STREAMS; i++) begin
                level_reg[i] <= '0;
                phase_reg[i] <= '0;
                held_reg[i]  <= RECIP_MAX;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                case (cfg_addr)
                    REG_RELEASE:    rel_coef_reg  <= cfg_data;
                    REG_OVERSAMPLE: os_factor_reg <= cfg_data[4:0];
                    default: ;
                endcase
            end
            if (state_reg == ST_IDLE && s_tvalid)
                phase_reg[s_tuser] <= (ph_inc >= factor) ? 4'd0 : ph_inc[3:0];
            if (state_reg == ST_DIV0) level_reg[slot_reg] <= env_reg;
            if (state_reg == ST_DIV0 && env_reg == '0) begin
                held_reg[slot_reg]       <= RECIP_MAX;
                slot_valid_reg[slot_reg] <= 1'b1;
            end
            if (state_reg == ST_DIV && div_done) begin
                held_reg[slot_reg]       <= div_q;
                slot_valid_reg[slot_reg] <= 1'b1;
            end
            if (out_load) m_valid_reg <= 1'b1;
            else if (m_tready) m_valid_reg <= 1'b0;
        end
    end

    hef_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqrt_start),
        .value   (sq_reg),
        .root    (sqrt_root),
        .done    (sqrt_done)
    );

    hef_recip u_recip (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .den     (env_reg),
        .quot    (div_q),
        .done    (div_done)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_slot_reg;
    assign m_tdata  = {7'd0, m_recip_reg, m_env_reg};
endmodule

[dv/hilbert_envelope_follower_tb.sv]
`timescale 1ns / 1ps
module hilbert_envelope_follower_tb;
    import hef_pkg::*;

    typedef struct packed {
        logic [2:0]  stream;
        logic [23:0] sample;
    } in_word_t;

    typedef struct packed {
        logic [2:0]         slot;
        logic [ENV_W-1:0]   envelope;
        logic [RECIP_W-1:0] reciprocal;
    } env_word_t;

    localparam int SETTLE_CYCLES = 400;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [15:0] cfg_data = '0;

    hilbert_envelope_follower DUT (.*);

    always #5 aclk = ~aclk;

    // filter model state
    logic signed [31:0] ap_delay [STREAMS*SLOT_WORDS];
    logic [ENV_W-1:0]   level_mem [STREAMS];
    logic [3:0]         phase_mem [STREAMS];
    logic [RECIP_W-1:0] recip_mem [STREAMS];
    logic [15:0]        alpha;
    logic [4:0]         group_len;

    in_word_t  pending_words [$];
    env_word_t expected_env [$];
    int        mismatches = 0;
    bit        quiet_tail = 1'b0;
    bit        in_taken = 1'b0;
    int        src_gap = 0;
    int        snk_gap = 0;

    function automatic logic signed [31:0] clip32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // product rounded to nearest, ties up, back to Q4.27
    function automatic logic signed [63:0] qmul(input logic signed [31:0] s,
                                                input logic signed [31:0] c);
        logic signed [63:0] p;
        p = 64'(s) * 64'(c) + 64'sd8388608;
        return p >>> 24;
    endfunction

    function automatic logic signed [31:0] allpass(input int base,
                                                   input logic signed [31:0] x,
                                                   input logic signed [31:0] c);
        logic signed [31:0] y;
        y = clip32(64'(ap_delay[base+1]) - qmul(x, c));
        ap_delay[base+1] = ap_delay[base];
        ap_delay[base] = clip32(64'(x) + qmul(y, c));
        return y;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic env_word_t follow_envelope(input in_word_t w);
        int slot, base;
        logic [4:0] glen;
        logic [4:0] ph;
        logic signed [31:0] x, a, re, im;
        logic [63:0] sq, mag, d, q;
        logic [31:0] env;
        const logic signed [31:0] c1[8] = '{16769391, 16727272, 16629309,
            16367803, 15668065, 13884142, 9914629, 3688505};
        const logic signed [31:0] c2[8] = '{16751688, 16689741, 16530376,
            16101368, 14973105, 12241872, 6932359, 1040021};
        env_word_t r;
        slot = w.stream % STREAMS;
        base = slot * SLOT_WORDS;
        glen = group_len == 0 ? 5'd1 : (group_len > 16 ? 5'd16 : group_len);
        ph = phase_mem[slot];
        if (ph == 0) begin
            x = {{4{w.sample[23]}}, w.sample, 4'b0};
            a = x;
            for (int k = 0; k < 8; k++) a = allpass(base + 2*k, a, c1[k]);
            re = ap_delay[base+32];
            ap_delay[base+32] = a;
            a = x;
            for (int k = 0; k < 8; k++) a = allpass(base + 16 + 2*k, a, c2[k]);
            im = a;
            sq = 64'(64'(re) * 64'(re)) + 64'(64'(im) * 64'(im));
            mag = int_sqrt(sq) >> 4;
            env = mag > 64'(ENV_MAX) ? 32'(ENV_MAX) : mag[31:0];
            if (env < level_mem[slot]) begin
                d = 64'(level_mem[slot] - env) * alpha + 64'd32768;
                env += d[47:16];
            end
            level_mem[slot] = env[ENV_W-1:0];
            if (env == 0) begin
                recip_mem[slot] = RECIP_MAX;
            end else begin
                q = (64'd1 << 39) / env;
                recip_mem[slot] = q > 64'hFFFFFFFF ? RECIP_MAX : q[31:0];
            end
        end
        ph++;
        if (ph >= glen) ph = 0;
        phase_mem[slot] = ph[3:0];
        r.slot = slot[2:0];
        r.envelope = level_mem[slot];
        r.reciprocal = recip_mem[slot];
        return r;
    endfunction

    // input handshake seen at the rising edge
    always @(posedge aclk) in_taken = aresetn && s_tvalid && s_tready;

    // driver
    always @(negedge aclk) begin
        if (in_taken) expected_env.push_back(follow_envelope({s_tuser, s_tdata}));
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            if (src_gap > 0) begin
                src_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_words.size() > 0) begin
                in_word_t w;
                w = pending_words.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= w.stream;
                s_tdata <= w.sample;
                if (!quiet_tail && $urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 15);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        if (quiet_tail || snk_gap == 0) begin
            m_tready <= aresetn;
            if (!quiet_tail && $urandom_range(0, 9) == 0) snk_gap = $urandom_range(1, 15);
        end else begin
            snk_gap--;
            m_tready <= 1'b0;
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            env_word_t want, got;
            got.slot = m_tuser;
            got.envelope = m_tdata[24:0];
            got.reciprocal = m_tdata[56:25];
            if (expected_env.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h", got);
            end else begin
                want = expected_env.pop_front();
                if (got.slot !== want.slot || got.envelope !== want.envelope
                    || got.reciprocal !== want.reciprocal) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch slot %0d/%0d env %h/%h recip %h/%h",
                                 want.slot, got.slot, want.envelope, got.envelope,
                                 want.reciprocal, got.reciprocal);
                end
            end
        end
    end

    task automatic drain();
        while (pending_words.size() > 0 || s_tvalid || expected_env.size() > 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        if (idx == REG_RELEASE) alpha = val;
        else group_len = val[4:0];
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [23:0] rand_sample();
        case ($urandom_range(0, 5))
            0:       return 24'h7FFFFF;
            1:       return 24'h800000;
            2:       return 24'($urandom_range(0, 255) - 128);
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic add_random(input int n);
        in_word_t w;
        for (int i = 0; i < n; i++) begin
            w.stream = 3'($urandom_range(0, 7));
            w.sample = rand_sample();
            pending_words.push_back(w);
        end
    endtask

    initial begin
        in_word_t w;
        for (int i = 0; i < STREAMS*SLOT_WORDS; i++) ap_delay[i] = 0;
        for (int i = 0; i < STREAMS; i++) begin
            level_mem[i] = 0;
            phase_mem[i] = 0;
            recip_mem[i] = RECIP_MAX;
        end
        alpha = 0;
        group_len = 1;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: zero input on every slot, full-scale steps on slots 0 and 1
        for (int i = 0; i < 8; i++) begin
            w.stream = 3'(i);
            w.sample = 24'h0;
            pending_words.push_back(w);
        end
        for (int i = 0; i < 12; i++) begin
            w.stream = 3'(i % 2);
            w.sample = i[0] ? 24'h800000 : 24'h7FFFFF;
            pending_words.push_back(w);
        end
        drain();

        // slow release with oversampling; sender pauses until idle
        write_reg(REG_RELEASE, 16'hFFFF);
        write_reg(REG_OVERSAMPLE, 16'd16);
        add_random(250);
        drain();
        write_reg(REG_RELEASE, 16'd0);
        write_reg(REG_OVERSAMPLE, 16'd0);
        add_random(200);
        drain();
        write_reg(REG_OVERSAMPLE, 16'd31);
        write_reg(REG_RELEASE, 16'h8000);
        add_random(200);
        drain();
        write_reg(REG_RELEASE, 16'($urandom));
        write_reg(REG_OVERSAMPLE, 16'd3);
        add_random(300);
        drain();
        write_reg(REG_OVERSAMPLE, 16'd1);
        write_reg(REG_RELEASE, 16'hF000);
        quiet_tail = 1'b1;
        add_random(200);
        drain();

        if (mismatches == 0 && expected_env.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #(20_000_000);
        $display("tb: failure");
        $finish;
    end
endmodule
